FILE: hw/rtl/dms_pkg.sv
package dms_pkg;

   localparam int unsigned KeyWidth = 32;
   localparam int unsigned TagWidth = 16;
   localparam int unsigned ItemWidth = KeyWidth + TagWidth;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_PASS,
      ST_FETCH,
      ST_MERGE,
      ST_COPY,
      ST_EMIT
   } state_type;

   // key in the low bits, matching tdata
   typedef struct packed {
      logic [TagWidth-1:0] tag;
      logic [KeyWidth-1:0] key;
   } item_type;

endpackage

FILE: hw/rtl/descending_merge_sorter.sv
// Descending merge sorter.
// Input beats on req_*: tdata = {item_tag, item_key}, tlast = item_last.
// Beats are stored one per cycle. A beat with tlast ends the list and
// starts a bottom-up merge over the stored items (same order as the
// top-down floor(n/2) split, ties taken from the upper half). Each width
// pass merges into scratch (a fetch step, then a merge step per item),
// then copies back, using one compare unit and one read port per memory;
// ceil(log2 n) passes. Sorted items leave on rsp_*, largest key first:
// tdata = {out_tag, out_key}, tlast = out_last, tuser = overflow;
// rsp_tvalid drops after each taken beat while the next item is read.
// req_tready is low from the last beat until the final result beat is taken.
// Results hold while rsp_tready is low. Items beyond MAX_ITEMS are dropped
// and flagged via tuser on the run.
// Reset empties the list and clears the drop flag; no clearing pass.
module descending_merge_sorter #(
   parameter int unsigned MAX_ITEMS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,  // item_key[31:0], item_tag[47:32]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,  // out_key[31:0], out_tag[47:32]
   output logic        rsp_tlast,
   output logic        rsp_tuser   // overflow
);

   localparam int unsigned AW = $clog2(MAX_ITEMS);
   localparam int unsigned CW = $clog2(MAX_ITEMS + 1);
   localparam int unsigned WW = $clog2(2 * MAX_ITEMS + 1);

   dms_pkg::state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          drop_ff, drop_in;
   logic [WW-1:0] width_ff, width_in;
   logic [WW-1:0] lo_ff, lo_in;
   logic [WW-1:0] a_ff, a_in, b_ff, b_in, w_ff, w_in;
   logic [WW-1:0] mid_ff, mid_in, hi_ff, hi_in;
   logic          phase_ff, phase_in;

   logic              s_we;
   logic [AW-1:0]     s_wa, s_ra;
   dms_pkg::item_type s_wd, s_rd;
   logic              t_we;
   logic [AW-1:0]     t_wa, t_ra;
   dms_pkg::item_type t_wd, t_rd;
   logic              u_we;
   logic [AW-1:0]     u_wa, u_ra;
   dms_pkg::item_type u_rd;

   // store read at a (port s) and b (port u: mirror copy), scratch port t
   dms_ram #(.WIDTH(dms_pkg::ItemWidth), .DEPTH(MAX_ITEMS)) u_store_a (
      .clock(clock), .wr_en(s_we), .wr_addr(s_wa), .wr_data(s_wd),
      .rd_addr(s_ra), .rd_data(s_rd)
   );
   dms_ram #(.WIDTH(dms_pkg::ItemWidth), .DEPTH(MAX_ITEMS)) u_store_b (
      .clock(clock), .wr_en(u_we), .wr_addr(u_wa), .wr_data(s_wd),
      .rd_addr(u_ra), .rd_data(u_rd)
   );
   dms_ram #(.WIDTH(dms_pkg::ItemWidth), .DEPTH(MAX_ITEMS)) u_scratch (
      .clock(clock), .wr_en(t_we), .wr_addr(t_wa), .wr_data(t_wd),
      .rd_addr(t_ra), .rd_data(t_rd)
   );

   logic take_a;
   logic [WW-1:0] cnt_w;
   logic [WW-1:0] nxt_lo;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          read_ok;

   assign cnt_w = WW'(count_ff);
   assign req_tready = (state_ff == dms_pkg::ST_LOAD);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = s_rd;
   assign rsp_tlast = (w_ff == cnt_w);
   assign rsp_tuser = drop_ff;

   always_comb begin
      logic a_live, b_live;
      a_live = (a_ff < mid_ff);
      b_live = (b_ff < hi_ff);
      take_a = a_live && (!b_live || (s_rd.key > u_rd.key));
      nxt_lo = lo_ff + (width_ff << 1);
   end

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      drop_in = drop_ff;
      width_in = width_ff;
      lo_in = lo_ff;
      a_in = a_ff; b_in = b_ff; w_in = w_ff;
      mid_in = mid_ff; hi_in = hi_ff;
      phase_in = phase_ff;
      rsp_valid_in = rsp_valid_ff;
      read_ok = 1'b0;
      s_we = 1'b0; u_we = 1'b0; t_we = 1'b0;
      s_wa = count_ff[AW-1:0]; u_wa = count_ff[AW-1:0];
      s_wd = req_tdata;
      t_wa = w_ff[AW-1:0];
      t_wd = take_a ? s_rd : u_rd;
      s_ra = a_ff[AW-1:0]; u_ra = b_ff[AW-1:0]; t_ra = w_ff[AW-1:0];
      unique case (state_ff)
         dms_pkg::ST_LOAD: begin
            if (req_tvalid) begin
               if (count_ff < CW'(MAX_ITEMS)) begin
                  s_we = 1'b1; u_we = 1'b1;
                  count_in = count_ff + 1'b1;
               end else begin
                  drop_in = 1'b1;
               end
               if (req_tlast) begin
                  state_in = dms_pkg::ST_PASS;
                  width_in = WW'(1);
                  lo_in = '0;
               end
            end
         end
         dms_pkg::ST_PASS: begin
            // bottom-up: blocks aligned from 0; ties from the upper block
            // give the same order as the top-down split
            if (width_ff >= cnt_w) begin
               state_in = dms_pkg::ST_EMIT;
               a_in = '0; w_in = WW'(1);
               rsp_valid_in = 1'b0;
               phase_in = 1'b0;
            end else if (lo_ff >= cnt_w) begin
               width_in = width_ff << 1;
               lo_in = '0;
            end else begin
               a_in = lo_ff; w_in = lo_ff;
               mid_in = (lo_ff + width_ff < cnt_w) ? lo_ff + width_ff : cnt_w;
               b_in = (lo_ff + width_ff < cnt_w) ? lo_ff + width_ff : cnt_w;
               hi_in = (nxt_lo < cnt_w) ? nxt_lo : cnt_w;
               state_in = dms_pkg::ST_FETCH;
            end
         end
         dms_pkg::ST_FETCH: begin
            state_in = dms_pkg::ST_MERGE;
         end
         dms_pkg::ST_MERGE: begin
            if (w_ff >= hi_ff) begin
               state_in = dms_pkg::ST_COPY;
               w_in = lo_ff;
               phase_in = 1'b0;
            end else begin
               t_we = 1'b1;
               w_in = w_ff + 1'b1;
               if (take_a) a_in = a_ff + 1'b1;
               else b_in = b_ff + 1'b1;
               state_in = dms_pkg::ST_FETCH;
            end
         end
         dms_pkg::ST_COPY: begin
            s_wa = w_ff[AW-1:0] - 1'b1; u_wa = s_wa;
            s_wd = t_rd;
            if (phase_ff) begin
               s_we = 1'b1; u_we = 1'b1;
            end
            if (w_ff >= hi_ff) begin
               if (phase_ff) begin
                  state_in = dms_pkg::ST_PASS;
                  lo_in = nxt_lo;
               end else begin
                  phase_in = 1'b1;
                  w_in = w_ff + 1'b1;
               end
            end else begin
               phase_in = 1'b1;
               w_in = w_ff + 1'b1;
            end
            if (w_ff >= hi_ff && phase_ff) begin
               s_we = 1'b1; u_we = 1'b1;
            end
         end
         dms_pkg::ST_EMIT: begin
            // a_ff: read pointer; w_ff: ordinal of item on rsp_tdata
            if (!rsp_valid_ff) begin
               if (!phase_ff) begin
                  phase_in = 1'b1;
                  a_in = a_ff + 1'b1;
               end else begin
                  rsp_valid_in = 1'b1;
               end
            end else if (rsp_tready) begin
               rsp_valid_in = 1'b0;
               s_ra = a_ff[AW-1:0];
               if (w_ff == cnt_w) begin
                  state_in = dms_pkg::ST_LOAD;
                  count_in = '0;
                  drop_in = 1'b0;
               end else begin
                  w_in = w_ff + 1'b1;
                  a_in = a_ff + 1'b1;
                  phase_in = 1'b1;
               end
            end
            if (rsp_valid_ff && !rsp_tready) s_ra = a_ff[AW-1:0] - 1'b1;
            if (!rsp_valid_ff && phase_ff) s_ra = a_ff[AW-1:0] - 1'b1;
            read_ok = 1'b1;
         end
         default: state_in = dms_pkg::ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dms_pkg::ST_LOAD;
         count_ff <= '0;
         drop_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         drop_ff <= drop_in;
         rsp_valid_ff <= rsp_valid_in && read_ok;
         phase_ff <= phase_in;
      end
      width_ff <= width_in;
      lo_ff <= lo_in;
      a_ff <= a_in; b_ff <= b_in; w_ff <= w_in;
      mid_ff <= mid_in; hi_ff <= hi_in;
   end

`ifndef ASSERT_OFF
   a_count_cap: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(MAX_ITEMS)) else $error("item count above capacity");
   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("accepting while emitting");
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> (count_ff == '0 && !drop_ff))
      else $error("run state not cleared");
`endif

endmodule

FILE: hw/rtl/dms_ram.sv
module dms_ram #(
   parameter int unsigned WIDTH = 48,
   parameter int unsigned DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

FILE: tb/sv/tb_descending_merge_sorter.sv
module tb_descending_merge_sorter;

   localparam int unsigned KeyWidth = dms_pkg::KeyWidth;
   localparam int unsigned TagWidth = dms_pkg::TagWidth;
   localparam int unsigned Capacity = 64;
   localparam int unsigned ListItems = 370;

   typedef struct packed {
      logic [KeyWidth-1:0] key;
      logic [TagWidth-1:0] tag;
      logic last;
      logic ovf;
   } sorted_beat_type;

   typedef struct packed {
      logic [KeyWidth-1:0] key;
      logic [TagWidth-1:0] tag;
      logic last;
      logic typed;
      logic [KeyWidth-1:0] exp_key;
      logic [TagWidth-1:0] exp_tag;
   } list_row_type;

   logic clock;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [47:0] req_tdata;  // item_key[31:0], item_tag[47:32]
   logic req_tlast;
   logic rsp_tvalid;
   logic rsp_tready;
   logic [47:0] rsp_tdata;  // out_key[31:0], out_tag[47:32]
   logic rsp_tlast;
   logic rsp_tuser;         // overflow

   descending_merge_sorter #(.MAX_ITEMS(Capacity)) u_dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser)
   );

   // predictor state
   logic [KeyWidth-1:0] sort_keys [Capacity];
   logic [TagWidth-1:0] sort_tags [Capacity];
   logic [KeyWidth-1:0] merge_keys [Capacity];
   logic [TagWidth-1:0] merge_tags [Capacity];
   int unsigned stored_count;
   bit drop_seen;

   sorted_beat_type sorted_queue[$];
   int unsigned errors;
   int unsigned beats_checked;
   int unsigned lists_sent;
   int unsigned items_sent;
   int unsigned overflow_lists;
   int unsigned stall_mode;

   list_row_type list_rows [21];

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   initial begin
      #4000000;
      $display("timeout at %0t", $time);
      $display("** descending_merge_sorter: FAILED **");
      $finish;
   end

   function automatic void merge_span(int unsigned lo, int unsigned mid, int unsigned hi);
      int unsigned a;
      int unsigned b;
      int unsigned w;
      a = lo;
      b = mid;
      for (w = lo; w < hi; w++) begin
         if (b >= hi || (a < mid && sort_keys[a] > sort_keys[b])) begin
            merge_keys[w] = sort_keys[a];
            merge_tags[w] = sort_tags[a];
            a++;
         end else begin
            merge_keys[w] = sort_keys[b];
            merge_tags[w] = sort_tags[b];
            b++;
         end
      end
      for (w = lo; w < hi; w++) begin
         sort_keys[w] = merge_keys[w];
         sort_tags[w] = merge_tags[w];
      end
   endfunction

   function automatic void sort_span(int unsigned lo, int unsigned hi);
      int unsigned mid;
      if (hi - lo <= 1) return;
      mid = lo + (hi - lo) / 2;
      sort_span(lo, mid);
      sort_span(mid, hi);
      merge_span(lo, mid, hi);
   endfunction

   // stores one item; on tlast pushes the sorted run unless typed results are given
   function automatic void predict_sorted(logic [KeyWidth-1:0] key, logic [TagWidth-1:0] tag,
                                          logic last, bit push);
      sorted_beat_type beat;
      if (stored_count < Capacity) begin
         sort_keys[stored_count] = key;
         sort_tags[stored_count] = tag;
         stored_count++;
      end else begin
         drop_seen = 1'b1;
      end
      if (!last) return;
      sort_span(0, stored_count);
      if (drop_seen) overflow_lists++;
      for (int unsigned i = 0; i < stored_count; i++) begin
         beat.key = sort_keys[i];
         beat.tag = sort_tags[i];
         beat.last = (i + 1 == stored_count);
         beat.ovf = drop_seen;
         if (push) sorted_queue.push_back(beat);
      end
      stored_count = 0;
      drop_seen = 1'b0;
      lists_sent++;
   endfunction

   task automatic send_item(logic [KeyWidth-1:0] key, logic [TagWidth-1:0] tag, logic last);
      req_tdata <= {tag, key};
      req_tlast <= last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic maybe_gap();
      int unsigned gap;
      if ($urandom_range(0, 3) == 0) begin
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   function automatic logic [KeyWidth-1:0] pick_key(int unsigned mode);
      case (mode)
         0: pick_key = $urandom;
         1: pick_key = $urandom_range(0, 3);
         2: pick_key = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
         default: pick_key = {3'($urandom_range(0, 7)), 29'h0} | 32'($urandom_range(0, 1));
      endcase
   endfunction

   always @(posedge clock) begin
      sorted_beat_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (sorted_queue.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat key=%h tag=%h last=%b ovf=%b", $time,
                     rsp_tdata[31:0], rsp_tdata[47:32], rsp_tlast, rsp_tuser);
         end else begin
            want = sorted_queue.pop_front();
            beats_checked++;
            if (rsp_tdata[31:0] !== want.key) begin
               errors++;
               $display("%0t: key expected %h actual %h", $time, want.key, rsp_tdata[31:0]);
            end
            if (rsp_tdata[47:32] !== want.tag) begin
               errors++;
               $display("%0t: tag expected %h actual %h", $time, want.tag, rsp_tdata[47:32]);
            end
            if (rsp_tlast !== want.last) begin
               errors++;
               $display("%0t: last expected %b actual %b", $time, want.last, rsp_tlast);
            end
            if (rsp_tuser !== want.ovf) begin
               errors++;
               $display("%0t: overflow expected %b actual %b", $time, want.ovf, rsp_tuser);
            end
         end
      end
   end

   // receiver stalls: always ready, random, or mostly stalled; mode hops every so often
   always @(posedge clock) begin
      if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= 1'($urandom_range(0, 1));
         default: rsp_tready <= ($urandom_range(0, 4) == 0);
      endcase
   end

   initial begin
      sorted_beat_type beat;
      int unsigned len;
      int unsigned kmode;
      int unsigned wait_cycles;
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tlast <= 1'b0;
      rsp_tready <= 1'b0;
      stall_mode = 0;
      errors = 0;
      beats_checked = 0;
      lists_sent = 0;
      items_sent = 0;
      overflow_lists = 0;
      stored_count = 0;
      drop_seen = 1'b0;
      list_rows = '{
         '{32'h0000_0000, 16'h0000, 1'b1, 1'b1, 32'h0000_0000, 16'h0000},
         '{32'hFFFF_FFFF, 16'hFFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 16'hFFFF},
         '{32'h0000_0001, 16'h0001, 1'b1, 1'b1, 32'h0000_0001, 16'h0001},
         '{32'h8000_0000, 16'h8000, 1'b1, 1'b1, 32'h8000_0000, 16'h8000},
         '{32'd5, 16'd1, 1'b0, 1'b0, '0, '0},
         '{32'd7, 16'd2, 1'b0, 1'b0, '0, '0},
         '{32'd5, 16'd3, 1'b0, 1'b0, '0, '0},
         '{32'd5, 16'd4, 1'b1, 1'b0, '0, '0},
         '{32'd1, 16'd5, 1'b0, 1'b0, '0, '0},
         '{32'd2, 16'd6, 1'b0, 1'b0, '0, '0},
         '{32'd3, 16'd7, 1'b1, 1'b0, '0, '0},
         '{32'hFFFF_FFFF, 16'h00AA, 1'b0, 1'b0, '0, '0},
         '{32'h0000_0000, 16'h00BB, 1'b0, 1'b0, '0, '0},
         '{32'hFFFF_FFFF, 16'h00CC, 1'b1, 1'b0, '0, '0},
         '{32'd9, 16'd10, 1'b0, 1'b0, '0, '0},
         '{32'd9, 16'd11, 1'b0, 1'b0, '0, '0},
         '{32'd9, 16'd12, 1'b0, 1'b0, '0, '0},
         '{32'd9, 16'd13, 1'b0, 1'b0, '0, '0},
         '{32'd9, 16'd14, 1'b1, 1'b0, '0, '0},
         '{32'd3, 16'h5555, 1'b0, 1'b0, '0, '0},
         '{32'd3, 16'hAAAA, 1'b1, 1'b0, '0, '0}
      };
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (list_rows[i]) begin
         send_item(list_rows[i].key, list_rows[i].tag, list_rows[i].last);
         predict_sorted(list_rows[i].key, list_rows[i].tag, list_rows[i].last,
                        !list_rows[i].typed);
         if (list_rows[i].typed) begin
            beat = '{list_rows[i].exp_key, list_rows[i].exp_tag, 1'b1, 1'b0};
            sorted_queue.push_back(beat);
         end
         maybe_gap();
      end

      while (items_sent < ListItems) begin
         case ($urandom_range(0, 19))
            0: len = $urandom_range(65, 70);
            1: len = Capacity;
            2, 3: len = $urandom_range(13, 63);
            default: len = $urandom_range(1, 12);
         endcase
         kmode = $urandom_range(0, 3);
         for (int unsigned n = 0; n < len; n++) begin
            logic [KeyWidth-1:0] key;
            logic [TagWidth-1:0] tag;
            key = pick_key(kmode);
            tag = 16'($urandom);
            send_item(key, tag, n + 1 == len);
            predict_sorted(key, tag, n + 1 == len, 1'b1);
            maybe_gap();
         end
      end
      req_tvalid <= 1'b0;

      wait_cycles = 0;
      while (sorted_queue.size() != 0 && wait_cycles < 200000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (200) @(posedge clock);
      $display("sorted %0d lists from %0d items, %0d with dropped items; %0d beats checked",
               lists_sent, items_sent, overflow_lists, beats_checked);
      if (errors == 0 && sorted_queue.size() == 0) begin
         $display("** descending_merge_sorter: PASSED **");
      end else begin
         $display("%0d mismatches, %0d beats never seen", errors, sorted_queue.size());
         $display("** descending_merge_sorter: FAILED **");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/dms_pkg.sv
hw/rtl/dms_ram.sv
hw/rtl/descending_merge_sorter.sv
tb/sv/tb_descending_merge_sorter.sv
